@@ rtl/core/etme_pkg.sv @@
// shared types and constants for the exclusion table with minimum-key eviction
`timescale 1ns / 1ps
package etme_pkg;

	localparam int KEY_W   = 64;
	localparam int DIR_W   = 2;
	localparam int ENTRY_W = KEY_W + DIR_W;
	localparam int CNT_W   = 6;

	// raw direction code of the wildcard (-1)
	localparam logic [DIR_W-1:0] DIR_ANY = 2'b11;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
	} dp_stat_t;

endpackage

@@ rtl/core/exclusion_table_min_evict.sv @@
// top level of the exclusion table with minimum-key eviction
`timescale 1ns / 1ps
//
// channel   direction  signals                                  handshake
// -------   ---------  ---------------------------------------  ----------------------
// command   in         command, channel_id, direction           start high, busy low
// result    out        hit, removed_count, entry_count          done high, one cycle
//
// the item is latched at its accept edge; its result strobe rises after the scan state,
// reading each held entry through the registered ram read port, then the commit state
// an empty table or a clear reads no entry from the ram in its scan
// busy drops as the result is registered, so the next item can be taken at the edge that
// ends the strobe; while an item is in scan or commit no new item is taken
// reset clears the fill level and the sequencer; table contents need no reset
// the receiver cannot stall: each result is valid for exactly one cycle
//
module exclusion_table_min_evict #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [63:0]       channel_id,
	input  logic signed [1:0] direction,
	output logic              done,
	output logic              hit,
	output logic [5:0]        removed_count,
	output logic [5:0]        entry_count
);
	import etme_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// sequencer: idle, scan every held entry, commit
	etme_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.ctl   (ctl),
		.busy  (busy)
	);

	// table ram, compaction for remove, lowest-id tracking for add when full
	etme_dp #(
		.DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.command      (command),
		.channel_id   (channel_id),
		.direction    (direction),
		.done         (done),
		.hit          (hit),
		.removed_count(removed_count),
		.entry_count  (entry_count)
	);

endmodule

@@ rtl/core/etme_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module etme_ram #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/etme_ctrl.sv @@
// command sequencer: idle, table scan, commit
`timescale 1ns / 1ps
module etme_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  etme_pkg::dp_stat_t   stat,
	output etme_pkg::ctrl_cmd_t  ctl,
	output logic                 busy
);
	import etme_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_end) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

@@ rtl/core/etme_dp.sv @@
// datapath: item registers, scan pointers, compaction, minimum tracking, results
`timescale 1ns / 1ps
module etme_dp #(
	parameter int DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  etme_pkg::ctrl_cmd_t ctl,
	output etme_pkg::dp_stat_t  stat,
	input  logic [1:0]          command,
	input  logic [63:0]         channel_id,
	input  logic signed [1:0]   direction,
	output logic                done,
	output logic                hit,
	output logic [5:0]          removed_count,
	output logic [5:0]          entry_count
);
	import etme_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [DIR_W-1:0] dir_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    rd_q;
	logic [CW-1:0]    wr_q;
	logic [CW-1:0]    gone_q;
	logic             found_q;
	logic [KEY_W-1:0] min_key_q;
	logic [IW-1:0]    min_idx_q;
	logic             rvalid_s1;
	logic [IW-1:0]    ridx_s1;
	logic             done_q;
	logic             hit_q;
	logic [5:0]       removed_q;
	logic [5:0]       count_q;

	logic [ENTRY_W-1:0] rdata;
	logic [KEY_W-1:0]   e_key;
	logic [DIR_W-1:0]   e_dir;
	logic [CW-1:0]      limit;
	logic               rd_more;
	logic               key_eq;
	logic               rm_match;
	logic               lk_match;
	logic               full;
	logic               we;
	logic [IW-1:0]      waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [CW-1:0]      fill_d;
	logic [CW+5:0]      fill_ext;
	logic [CW+5:0]      gone_ext;

	assign e_key    = rdata[ENTRY_W-1:DIR_W];
	assign e_dir    = rdata[DIR_W-1:0];
	// clear needs no pass over the table
	assign limit    = (cmd_q == CMD_CLEAR) ? '0 : fill_q;
	assign rd_more  = (rd_q != limit);
	assign key_eq   = (e_key == key_q);
	assign rm_match = key_eq && ((dir_q == DIR_ANY) || (e_dir == dir_q));
	assign lk_match = key_eq && ((e_dir == DIR_ANY) || (e_dir == dir_q));
	assign full     = (fill_q == CW'(DEPTH));

	assign stat.scan_end = !rd_more && !rvalid_s1;

	// write port: compaction during remove scan, insert at add commit
	always_comb begin
		we    = 1'b0;
		waddr = wr_q[IW-1:0];
		wdata = rdata;
		if (ctl.scan && rvalid_s1 && (cmd_q == CMD_REMOVE) && !rm_match) begin
			we = 1'b1;
		end else if (ctl.commit && (cmd_q == CMD_ADD) && !found_q) begin
			we    = 1'b1;
			waddr = full ? min_idx_q : fill_q[IW-1:0];
			wdata = {key_q, dir_q};
		end
	end

	always_comb begin
		fill_d = fill_q;
		unique case (cmd_q)
			CMD_ADD:    fill_d = (!found_q && !full) ? fill_q + CW'(1) : fill_q;
			CMD_REMOVE: fill_d = wr_q;
			CMD_LOOKUP: fill_d = fill_q;
			CMD_CLEAR:  fill_d = '0;
			default:    fill_d = fill_q;
		endcase
	end

	// counts report their low six bits
	assign fill_ext = {6'b0, fill_d};
	assign gone_ext = {6'b0, gone_q};

	etme_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_q[IW-1:0]),
		.rdata(rdata)
	);

	// item and scan payload, read index and result registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_t'(command);
			key_q   <= channel_id;
			dir_q   <= direction;
			rd_q    <= '0;
			wr_q    <= '0;
			gone_q  <= '0;
			found_q <= 1'b0;
		end else if (ctl.scan) begin
			if (rd_more) begin
				rd_q <= rd_q + CW'(1);
			end
			if (rvalid_s1) begin
				unique case (cmd_q)
					CMD_ADD: begin
						if (key_eq && (e_dir == dir_q)) begin
							found_q <= 1'b1;
						end
						if ((ridx_s1 == '0) || (e_key < min_key_q)) begin
							min_key_q <= e_key;
							min_idx_q <= ridx_s1;
						end
					end
					CMD_REMOVE: begin
						if (rm_match) begin
							gone_q <= gone_q + CW'(1);
						end else begin
							wr_q <= wr_q + CW'(1);
						end
					end
					CMD_LOOKUP: begin
						if (lk_match) begin
							found_q <= 1'b1;
						end
					end
					CMD_CLEAR: begin
						found_q <= 1'b0;
					end
					default: begin
						found_q <= found_q;
					end
				endcase
			end
		end
		ridx_s1   <= rd_q[IW-1:0];
		hit_q     <= (cmd_q == CMD_ADD) || ((cmd_q == CMD_LOOKUP) && found_q);
		removed_q <= (cmd_q == CMD_REMOVE) ? gone_ext[5:0] : 6'd0;
		count_q   <= fill_ext[5:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rvalid_s1 <= ctl.scan && rd_more;
			done_q    <= ctl.commit;
			if (ctl.commit) begin
				fill_q <= fill_d;
			end
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign removed_count = removed_q;
	assign entry_count   = count_q;

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the exclusion table with minimum-key eviction
`timescale 1ns / 1ps
module testbench;
	import etme_pkg::*;

	localparam int DEPTH      = 32;
	localparam int N_RANDOM   = 850;
	localparam int POOL_SIZE  = 16;
	// margin sized from the table depth, covers any item still in flight
	localparam int DRAIN_CYC  = DEPTH + 16;

	// plain direction codes besides the wildcard from the package
	localparam logic [1:0] DIR_IN   = 2'b00;
	localparam logic [1:0] DIR_OUT  = 2'b01;
	localparam logic [1:0] DIR_BAD  = 2'b10;  // -2, stored like any direction

	localparam logic [63:0] ID_MIN = 64'h0000_0000_0000_0000;
	localparam logic [63:0] ID_MAX = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] ID_A5  = 64'h5555_5555_5555_5555;
	localparam logic [63:0] ID_AA  = 64'haaaa_aaaa_aaaa_aaaa;

	// one command item plus the sender idle rate used while it waits
	typedef struct {
		cmd_t        op;
		logic [63:0] id;
		logic [1:0]  dir;
		int unsigned idle_pct;
	} table_cmd_t;

	// what the block reports for one command
	typedef struct {
		logic       hit;
		logic [5:0] removed;
		logic [5:0] count;
	} table_status_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        command = CMD_CLEAR;
	logic [63:0]       channel_id = '0;
	logic signed [1:0] direction = '0;
	logic              done;
	logic              hit;
	logic [5:0]        removed_count;
	logic [5:0]        entry_count;

	// shadow of the table contents and fill level
	logic [63:0] excl_key [DEPTH];
	logic [1:0]  excl_dir [DEPTH];
	int unsigned excl_fill = 0;

	table_cmd_t    cmd_backlog [$];     // items not yet handed to the driver
	table_status_t status_due [$];      // predicted results, oldest first
	table_cmd_t    on_bus;              // item currently offered on the ports
	bit            holding = 1'b0;      // on_bus still waits for acceptance
	int unsigned   err_count = 0;
	logic [63:0]   id_pool [POOL_SIZE];

	exclusion_table_min_evict #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.channel_id   (channel_id),
		.direction    (direction),
		.done         (done),
		.hit          (hit),
		.removed_count(removed_count),
		.entry_count  (entry_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// apply one command to the shadow table and return the expected status
	function automatic table_status_t table_apply(table_cmd_t c);
		table_status_t r;
		int unsigned   i;
		int unsigned   wr;
		int unsigned   low;
		bit            found;
		r.hit = 1'b0;
		r.removed = '0;
		found = 1'b0;
		case (c.op)
			CMD_ADD: begin
				r.hit = 1'b1;
				for (i = 0; i < excl_fill; i++)
					if (excl_key[i] == c.id && excl_dir[i] == c.dir)
						found = 1'b1;
				if (!found) begin
					if (excl_fill < DEPTH) begin
						excl_key[excl_fill] = c.id;
						excl_dir[excl_fill] = c.dir;
						excl_fill++;
					end else begin
						// full: the first entry holding the lowest id is replaced
						low = 0;
						for (i = 1; i < excl_fill; i++)
							if (excl_key[i] < excl_key[low])
								low = i;
						excl_key[low] = c.id;
						excl_dir[low] = c.dir;
					end
				end
			end
			CMD_REMOVE: begin
				// compact survivors toward the front, order kept
				wr = 0;
				for (i = 0; i < excl_fill; i++) begin
					if (excl_key[i] == c.id && (c.dir == DIR_ANY || excl_dir[i] == c.dir)) begin
						r.removed++;
					end else begin
						excl_key[wr] = excl_key[i];
						excl_dir[wr] = excl_dir[i];
						wr++;
					end
				end
				excl_fill = wr;
			end
			CMD_LOOKUP: begin
				// stored wildcard matches any asked direction, not the reverse
				for (i = 0; i < excl_fill; i++)
					if (excl_key[i] == c.id && (excl_dir[i] == DIR_ANY || excl_dir[i] == c.dir))
						r.hit = 1'b1;
			end
			default: begin
				excl_fill = 0;
			end
		endcase
		r.count = excl_fill[5:0];
		return r;
	endfunction

	function automatic void queue_cmd(cmd_t op, logic [63:0] id, logic [1:0] dir,
	                                  int unsigned idle_pct);
		table_cmd_t c;
		c.op = op;
		c.id = id;
		c.dir = dir;
		c.idle_pct = idle_pct;
		cmd_backlog.push_back(c);
	endfunction

	// ids mostly from the shared pool so that hits and removals happen
	function automatic logic [63:0] pick_id();
		if ($urandom_range(99) < 85)
			return id_pool[$urandom_range(POOL_SIZE - 1)];
		return {$urandom, $urandom};
	endfunction

	// driver: on acceptance predict, then offer the next item or idle
	always @(posedge clk) begin
		logic offer;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				status_due.push_back(table_apply(on_bus));
				holding = 1'b0;
			end
			if (!holding && cmd_backlog.size() > 0) begin
				on_bus = cmd_backlog.pop_front();
				holding = 1'b1;
			end
			// random sender gaps; zero rate gives back-to-back offers
			offer = holding && ($urandom_range(99) >= on_bus.idle_pct);
			start <= offer;
			if (holding) begin
				command    <= on_bus.op;
				channel_id <= on_bus.id;
				direction  <= on_bus.dir;
			end
		end
	end

	// monitor: every strobe is checked against the oldest prediction
	always @(posedge clk) begin
		table_status_t want;
		if (arst_n && done === 1'b1) begin
			if (status_due.size() == 0) begin
				$error("result strobe with no item outstanding");
				err_count++;
			end else begin
				want = status_due.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					err_count++;
				end
				if (removed_count !== want.removed) begin
					$error("removed_count: expected %0d, got %0d", want.removed, removed_count);
					err_count++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					err_count++;
				end
			end
		end
	end

	// reset asserted from time zero, released once
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// stimulus build-up and end of run
	initial begin
		int unsigned made;
		int unsigned kind;
		int unsigned len;
		int unsigned pct;
		int unsigned sel;
		int unsigned k;

		id_pool[0] = ID_MIN;
		id_pool[1] = ID_MAX;
		id_pool[2] = 64'h8000_0000_0000_0000;
		id_pool[3] = 64'h0000_0000_0000_0001;
		for (k = 4; k < POOL_SIZE; k++)
			id_pool[k] = {$urandom, $urandom};

		// directed: empty table, extremes of id, all four direction codes,
		// duplicate add, wildcard rules on both sides, compaction, clear
		queue_cmd(CMD_CLEAR,  ID_MIN, DIR_IN,  0);
		queue_cmd(CMD_LOOKUP, ID_MIN, DIR_IN,  0);
		queue_cmd(CMD_REMOVE, ID_MIN, DIR_ANY, 0);
		queue_cmd(CMD_ADD,    ID_MIN, DIR_IN,  0);
		queue_cmd(CMD_ADD,    ID_MAX, DIR_OUT, 0);
		queue_cmd(CMD_ADD,    ID_MAX, DIR_ANY, 0);
		queue_cmd(CMD_ADD,    ID_A5,  DIR_BAD, 0);
		queue_cmd(CMD_ADD,    ID_MIN, DIR_IN,  0);   // exact duplicate, no change
		queue_cmd(CMD_LOOKUP, ID_MAX, DIR_IN,  0);   // hit through stored wildcard
		queue_cmd(CMD_LOOKUP, ID_MIN, DIR_OUT, 0);   // miss on direction
		queue_cmd(CMD_LOOKUP, ID_A5,  DIR_BAD, 0);   // -2 matches only itself
		queue_cmd(CMD_LOOKUP, ID_A5,  DIR_ANY, 0);   // asked wildcard is not a wildcard
		queue_cmd(CMD_REMOVE, ID_MAX, DIR_IN,  0);   // stored wildcard survives
		queue_cmd(CMD_REMOVE, ID_MAX, DIR_OUT, 0);
		queue_cmd(CMD_ADD,    ID_MAX, DIR_OUT, 0);
		queue_cmd(CMD_REMOVE, ID_MAX, DIR_ANY, 0);   // removes both directions
		queue_cmd(CMD_LOOKUP, ID_MAX, DIR_ANY, 0);
		queue_cmd(CMD_ADD,    ID_AA,  DIR_OUT, 0);
		queue_cmd(CMD_REMOVE, ID_MIN, DIR_IN,  0);   // head removed, rest shifts
		queue_cmd(CMD_LOOKUP, ID_AA,  DIR_OUT, 0);
		queue_cmd(CMD_CLEAR,  ID_AA,  DIR_OUT, 0);
		queue_cmd(CMD_LOOKUP, ID_AA,  DIR_OUT, 0);   // gone after clear

		// random: short sequences, idle rate switching every ~100 items
		made = 0;
		while (made < N_RANDOM) begin
			case ((made / 100) % 3)
				0:       pct = 0;
				1:       pct = 56;
				default: pct = 12;
			endcase
			kind = $urandom_range(99);
			if (kind < 20) begin
				// fill past capacity so eviction runs, small ids make ties on the minimum
				if ($urandom_range(1))
					queue_cmd(CMD_CLEAR, pick_id(), 2'($urandom_range(3)), pct);
				len = $urandom_range(40, 30);
				for (k = 0; k < len; k++) begin
					sel = $urandom_range(3);
					queue_cmd(CMD_ADD,
					          (sel == 0) ? pick_id() :
					          (sel == 1) ? 64'($urandom_range(7)) : {$urandom, $urandom},
					          2'($urandom_range(3)), pct);
				end
				for (k = 0; k < 4; k++)
					queue_cmd(CMD_LOOKUP, 64'($urandom_range(7)), 2'($urandom_range(3)), pct);
				made += len + 5;
			end else if (kind < 85) begin
				// mixed traffic on pooled ids, clears kept rare so the table stays busy
				len = $urandom_range(25, 10);
				for (k = 0; k < len; k++) begin
					sel = $urandom_range(99);
					queue_cmd((sel < 45) ? CMD_ADD : (sel < 65) ? CMD_REMOVE :
					          (sel < 97) ? CMD_LOOKUP : CMD_CLEAR,
					          pick_id(), 2'($urandom_range(3)), pct);
				end
				made += len;
			end else begin
				// noise: anything goes
				len = $urandom_range(8, 3);
				for (k = 0; k < len; k++)
					queue_cmd(cmd_t'($urandom_range(3)), {$urandom, $urandom},
					          2'($urandom_range(3)), pct);
				made += len;
			end
		end

		// wait until every item is taken and answered, checked away from the edge
		do @(negedge clk);
		while (cmd_backlog.size() > 0 || holding || status_due.size() > 0);
		repeat (DRAIN_CYC) @(negedge clk);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/etme_pkg.sv
rtl/core/etme_ram.sv
rtl/core/etme_ctrl.sv
rtl/core/etme_dp.sv
rtl/core/exclusion_table_min_evict.sv
tb/sv/testbench.sv
